/* hw/rtl/prq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// prq_pkg - shared types and constants of the priority ready queue
// Beat formats, operation and status codes, default sizes.
// ---------------------------------------------------------------------------
package prq_pkg;

  // default sizes
  localparam int DEF_NUM_PRIORITIES = 32;
  localparam int DEF_NUM_TASKS      = 32;

  // beat field widths
  localparam int MODE_W   = 2;
  localparam int TASK_W   = 5;
  localparam int PRIO_W   = 5;
  localparam int STATUS_W = 2;

  // bitmap scan: levels examined per cycle
  localparam int SCAN_GROUP_W = 8;
  localparam int SCAN_ENC_W   = $clog2(SCAN_GROUP_W);

  // operation codes
  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SCHED  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP_ADD    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_QUEUED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NONE_READY = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [TASK_W-1:0] task_id;
    logic [PRIO_W-1:0] priority_req;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TASK_W-1:0]   next_task;
    logic [PRIO_W-1:0]   next_priority;
    logic                switch_needed;
  } out_item_t;

  // scan unit status toward the sequencer
  typedef struct packed {
    logic done;
    logic found;
  } scan_sts_t;

endpackage
`default_nettype wire

/* hw/rtl/prq_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// prq_ram - generic simple dual port ram
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module prq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds while idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/prq_scan.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// prq_scan - ready bitmap scanner
// Walks the ready bitmap one group of levels per cycle from level 0 and
// reports the lowest ready level.
// ---------------------------------------------------------------------------
module prq_scan #(
  parameter int NUM_PRIORITIES = prq_pkg::DEF_NUM_PRIORITIES,
  localparam int LW = $clog2(NUM_PRIORITIES)
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [NUM_PRIORITIES-1:0] bitmap,
  output prq_pkg::scan_sts_t             sts,
  output logic      [LW-1:0]             level
);

  localparam int GRP_W  = prq_pkg::SCAN_GROUP_W;
  localparam int GROUPS = (NUM_PRIORITIES + GRP_W - 1) / GRP_W;
  localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int PW     = GROUPS * GRP_W;

  logic                            busy_r;
  logic                            busy_nxt;
  logic [GW-1:0]                   grp_r;
  logic [GW-1:0]                   grp_nxt;
  logic [PW-1:0]                   padded;
  logic [GRP_W-1:0]                sel;
  logic [prq_pkg::SCAN_ENC_W-1:0]  enc;
  logic                            last_grp;

  assign padded   = PW'(bitmap);
  assign sel      = padded[grp_r*GRP_W +: GRP_W];
  assign last_grp = (grp_r == GW'(GROUPS - 1));

  // lowest set bit within the current group
  always_comb begin
    enc = '0;
    for (int i = GRP_W - 1; i >= 0; i--) begin
      if (sel[i]) begin
        enc = prq_pkg::SCAN_ENC_W'(i);
      end
    end
  end

  assign level = LW'({grp_r, enc});
  assign sts   = '{done:  busy_r && ((sel != '0) || last_grp),
                   found: busy_r && (sel != '0)};

  // group counter
  always_comb begin
    busy_nxt = busy_r;
    grp_nxt  = grp_r;
    if (start) begin
      busy_nxt = 1'b1;
      grp_nxt  = '0;
    end else if (sts.done) begin
      busy_nxt = 1'b0;
    end else if (busy_r) begin
      grp_nxt = grp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
  end

endmodule
`default_nettype wire

/* hw/rtl/priority_ready_queue_scheduler.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// priority_ready_queue_scheduler - bitmap priority ready queue
// One FIFO of task ids per priority level, kept as doubly linked lists in
// link rams, plus a ready bitmap; add, remove and schedule operations.
// ---------------------------------------------------------------------------
// The block takes one beat at a time and holds in_stall high until its work
// is done. Add onto an empty level writes the head, tail and level rams
// directly, add onto a busy level first reads the tail ram, remove reads the
// level and link rams and then the head and tail rams, and schedule scans the
// ready bitmap one group of 8 levels at a time and then reads the head ram.
// Results wait in an output register, so a new beat is taken while the
// previous result is still stalled. Rams need no clearing after reset: only
// entries of queued tasks and ready levels are ever read. Errors (duplicate
// add, removal of a task that is not queued, schedule with nothing ready)
// return a status code and leave the state unchanged. Removing the current
// task does not change it; the next schedule does.
module priority_ready_queue_scheduler #(
  parameter int NUM_PRIORITIES = prq_pkg::DEF_NUM_PRIORITIES,
  parameter int NUM_TASKS      = prq_pkg::DEF_NUM_TASKS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire prq_pkg::in_item_t in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output prq_pkg::out_item_t out_data
);

  localparam int TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int LW = $clog2(NUM_PRIORITIES);

  // sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_RD_LVL  = 3'd1;
  localparam logic [2:0] S_RD_HT   = 3'd2;
  localparam logic [2:0] S_SCAN    = 3'd3;
  localparam logic [2:0] S_RD_HEAD = 3'd4;
  localparam logic [2:0] S_FIN     = 3'd5;

  logic [2:0]                    state_r, state_nxt;
  logic [prq_pkg::MODE_W-1:0]    op_r, op_nxt;
  logic [TW-1:0]                 tid_r, tid_nxt;
  logic [LW-1:0]                 lvl_r, lvl_nxt;
  logic [TW-1:0]                 nxt_r, nxt_nxt;
  logic [TW-1:0]                 prv_r, prv_nxt;
  prq_pkg::out_item_t            res_r, res_nxt;

  logic                          out_valid_r, out_valid_nxt;
  prq_pkg::out_item_t            out_data_r, out_data_nxt;

  logic [NUM_PRIORITIES-1:0]     ready_r;
  logic [NUM_TASKS-1:0]          queued_r;
  logic                          run_valid_r, run_valid_nxt;
  logic [TW-1:0]                 run_task_r, run_task_nxt;

  // bitmap and queued flag updates
  logic                          rdy_set, rdy_clr;
  logic [LW-1:0]                 rdy_idx;
  logic                          q_set, q_clr;
  logic [TW-1:0]                 q_idx;

  // input decode
  logic [TW-1:0]                 tid_in;
  logic [LW-1:0]                 lvl_in;
  logic                          tid_ok;

  // ram ports
  logic          nl_we, nl_re, pl_we, pl_re, tl_we, tl_re;
  logic          hd_we, hd_re, tt_we, tt_re;
  logic [TW-1:0] nl_wa, nl_ra, nl_wd, nl_rd;
  logic [TW-1:0] pl_wa, pl_ra, pl_wd, pl_rd;
  logic [TW-1:0] tl_wa, tl_ra;
  logic [LW-1:0] tl_wd, tl_rd;
  logic [LW-1:0] hd_wa, hd_ra, tt_wa, tt_ra;
  logic [TW-1:0] hd_wd, hd_rd, tt_wd, tt_rd;

  // scanner
  logic                  scan_start;
  prq_pkg::scan_sts_t    scan_sts;
  logic [LW-1:0]         scan_lvl;

  logic                  is_head, is_tail;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign tid_in = TW'(in_data.task_id);
  assign tid_ok = (32'(in_data.task_id) < NUM_TASKS);
  assign lvl_in = (32'(in_data.priority_req) >= NUM_PRIORITIES) ?
                  LW'(NUM_PRIORITIES - 1) : LW'(in_data.priority_req);

  assign is_head = (hd_rd == tid_r);
  assign is_tail = (tt_rd == tid_r);

  // link, level, head and tail memories
  prq_ram #(.WIDTH(TW), .DEPTH(NUM_TASKS)) u_next_link (
    .clk(clk), .we(nl_we), .waddr(nl_wa), .wdata(nl_wd),
    .re(nl_re), .raddr(nl_ra), .rdata(nl_rd)
  );

  prq_ram #(.WIDTH(TW), .DEPTH(NUM_TASKS)) u_prev_link (
    .clk(clk), .we(pl_we), .waddr(pl_wa), .wdata(pl_wd),
    .re(pl_re), .raddr(pl_ra), .rdata(pl_rd)
  );

  prq_ram #(.WIDTH(LW), .DEPTH(NUM_TASKS)) u_task_level (
    .clk(clk), .we(tl_we), .waddr(tl_wa), .wdata(tl_wd),
    .re(tl_re), .raddr(tl_ra), .rdata(tl_rd)
  );

  prq_ram #(.WIDTH(TW), .DEPTH(NUM_PRIORITIES)) u_list_head (
    .clk(clk), .we(hd_we), .waddr(hd_wa), .wdata(hd_wd),
    .re(hd_re), .raddr(hd_ra), .rdata(hd_rd)
  );

  prq_ram #(.WIDTH(TW), .DEPTH(NUM_PRIORITIES)) u_list_tail (
    .clk(clk), .we(tt_we), .waddr(tt_wa), .wdata(tt_wd),
    .re(tt_re), .raddr(tt_ra), .rdata(tt_rd)
  );

  prq_scan #(.NUM_PRIORITIES(NUM_PRIORITIES)) u_scan (
    .clk(clk), .rst_n(rst_n), .start(scan_start), .bitmap(ready_r),
    .sts(scan_sts), .level(scan_lvl)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    tid_nxt       = tid_r;
    lvl_nxt       = lvl_r;
    nxt_nxt       = nxt_r;
    prv_nxt       = prv_r;
    res_nxt       = res_r;
    run_valid_nxt = run_valid_r;
    run_task_nxt  = run_task_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    rdy_set = 1'b0;  rdy_clr = 1'b0;  rdy_idx = lvl_r;
    q_set   = 1'b0;  q_clr   = 1'b0;  q_idx   = tid_r;
    scan_start = 1'b0;
    nl_we = 1'b0; nl_wa = '0; nl_wd = '0; nl_re = 1'b0; nl_ra = '0;
    pl_we = 1'b0; pl_wa = '0; pl_wd = '0; pl_re = 1'b0; pl_ra = '0;
    tl_we = 1'b0; tl_wa = '0; tl_wd = '0; tl_re = 1'b0; tl_ra = '0;
    hd_we = 1'b0; hd_wa = '0; hd_wd = '0; hd_re = 1'b0; hd_ra = '0;
    tt_we = 1'b0; tt_wa = '0; tt_wd = '0; tt_re = 1'b0; tt_ra = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt  = in_data.mode;
          tid_nxt = tid_in;
          lvl_nxt = lvl_in;
          res_nxt = '0;
          unique case (in_data.mode)
            prq_pkg::MODE_ADD: begin
              if (!tid_ok || queued_r[tid_in]) begin
                res_nxt.status = prq_pkg::ST_DUP_ADD;
                state_nxt      = S_FIN;
              end else if (ready_r[lvl_in]) begin
                // level busy: fetch its tail first
                tt_re     = 1'b1;
                tt_ra     = lvl_in;
                state_nxt = S_RD_HT;
              end else begin
                // empty level: task becomes head and tail
                hd_we = 1'b1; hd_wa = lvl_in; hd_wd = tid_in;
                tt_we = 1'b1; tt_wa = lvl_in; tt_wd = tid_in;
                tl_we = 1'b1; tl_wa = tid_in; tl_wd = lvl_in;
                rdy_set   = 1'b1;
                rdy_idx   = lvl_in;
                q_set     = 1'b1;
                q_idx     = tid_in;
                state_nxt = S_FIN;
              end
            end
            prq_pkg::MODE_REMOVE: begin
              if (!tid_ok || !queued_r[tid_in]) begin
                res_nxt.status = prq_pkg::ST_NOT_QUEUED;
                state_nxt      = S_FIN;
              end else begin
                tl_re = 1'b1; tl_ra = tid_in;
                nl_re = 1'b1; nl_ra = tid_in;
                pl_re = 1'b1; pl_ra = tid_in;
                state_nxt = S_RD_LVL;
              end
            end
            prq_pkg::MODE_SCHED: begin
              scan_start = 1'b1;
              state_nxt  = S_SCAN;
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end

      // remove: level and neighbors known, fetch head and tail
      S_RD_LVL: begin
        lvl_nxt = tl_rd;
        nxt_nxt = nl_rd;
        prv_nxt = pl_rd;
        hd_re = 1'b1; hd_ra = tl_rd;
        tt_re = 1'b1; tt_ra = tl_rd;
        state_nxt = S_RD_HT;
      end

      // link update for add onto a busy level, or for remove
      S_RD_HT: begin
        if (op_r == prq_pkg::MODE_ADD) begin
          nl_we = 1'b1; nl_wa = tt_rd; nl_wd = tid_r;
          pl_we = 1'b1; pl_wa = tid_r; pl_wd = tt_rd;
          tt_we = 1'b1; tt_wa = lvl_r; tt_wd = tid_r;
          tl_we = 1'b1; tl_wa = tid_r; tl_wd = lvl_r;
          q_set = 1'b1;
        end else begin
          priority if (is_head && is_tail) begin
            rdy_clr = 1'b1;
          end else if (is_head) begin
            hd_we = 1'b1; hd_wa = lvl_r; hd_wd = nxt_r;
          end else if (is_tail) begin
            tt_we = 1'b1; tt_wa = lvl_r; tt_wd = prv_r;
          end else begin
            nl_we = 1'b1; nl_wa = prv_r; nl_wd = nxt_r;
            pl_we = 1'b1; pl_wa = nxt_r; pl_wd = prv_r;
          end
          q_clr = 1'b1;
        end
        state_nxt = S_FIN;
      end

      // schedule: wait for the lowest ready level
      S_SCAN: begin
        if (scan_sts.done) begin
          if (scan_sts.found) begin
            hd_re     = 1'b1;
            hd_ra     = scan_lvl;
            lvl_nxt   = scan_lvl;
            state_nxt = S_RD_HEAD;
          end else begin
            res_nxt.status = prq_pkg::ST_NONE_READY;
            state_nxt      = S_FIN;
          end
        end
      end

      // schedule: head of that level becomes the current task
      S_RD_HEAD: begin
        res_nxt.next_task     = prq_pkg::TASK_W'(hd_rd);
        res_nxt.next_priority = prq_pkg::PRIO_W'(lvl_r);
        res_nxt.switch_needed = !run_valid_r || (run_task_r != hd_rd);
        run_valid_nxt = 1'b1;
        run_task_nxt  = hd_rd;
        state_nxt     = S_FIN;
      end

      // hand the result to the output register once it is free
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ready_r     <= '0;
      queued_r    <= '0;
      run_valid_r <= 1'b0;
      run_task_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      run_valid_r <= run_valid_nxt;
      run_task_r  <= run_task_nxt;
      if (rdy_set) begin
        ready_r[rdy_idx] <= 1'b1;
      end else if (rdy_clr) begin
        ready_r[rdy_idx] <= 1'b0;
      end
      if (q_set) begin
        queued_r[q_idx] <= 1'b1;
      end else if (q_clr) begin
        queued_r[q_idx] <= 1'b0;
      end
    end
  end

  // operands and result
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    tid_r      <= tid_nxt;
    lvl_r      <= lvl_nxt;
    nxt_r      <= nxt_nxt;
    prv_r      <= prv_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire
